// ----- sv/jsu_pkg.sv -----
// Package: types, character codes and helpers for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } jsu_phase_t;

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_DONE    = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_BADESC  = 3'd3,
    ST_BADHEX  = 3'd4,
    ST_SURR    = 3'd5,
    ST_UNTERM  = 3'd6
  } jsu_status_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam int MAX_RES = 3;

  // Up to three result bytes of one request, bytes[0] goes out first.
  typedef struct packed {
    logic [1:0]                cnt;
    jsu_status_t               status;
    logic [MAX_RES-1:0][7:0]   bytes;
  } jsu_result_t;

  // {valid, nibble} for one ASCII hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/jsu_decode.sv -----
// Decoder: escape state registers and the per-byte decode into up to three results.
`default_nettype none

module jsu_decode
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  byte_i,
  input  wire logic        eos_i,
  output jsu_result_t      res
);

  jsu_phase_t  phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [11:0] part_r, part_nxt;

  logic        fin;
  jsu_status_t fin_status;
  logic [4:0]  hv;
  logic [15:0] cp;

  always_comb begin
    phase_nxt   = phase_r;
    hex_cnt_nxt = hex_cnt_r;
    part_nxt    = part_r;
    fin         = 1'b0;
    fin_status  = ST_DONE;
    res.cnt     = 2'd1;
    res.status  = ST_DATA;
    res.bytes   = '0;
    hv          = hex_val(byte_i);
    cp          = {part_r, hv[3:0]};

    case (phase_r)
      PH_IDLE: begin
        if (!eos_i && byte_i == CH_QUOTE) begin
          phase_nxt = PH_STR;
          res.cnt   = 2'd0;
        end else begin
          fin        = 1'b1;
          fin_status = ST_NOQUOTE;
        end
      end
      PH_STR: begin
        if (eos_i) begin
          fin        = 1'b1;
          fin_status = ST_UNTERM;
        end else if (byte_i == CH_QUOTE) begin
          fin        = 1'b1;
          fin_status = ST_DONE;
        end else if (byte_i == CH_BSLASH) begin
          phase_nxt = PH_ESC;
          res.cnt   = 2'd0;
        end else begin
          res.bytes[0] = byte_i;
        end
      end
      PH_ESC: begin
        if (eos_i) begin
          fin        = 1'b1;
          fin_status = ST_UNTERM;
        end else begin
          phase_nxt = PH_STR;
          case (byte_i)
            CH_QUOTE:  res.bytes[0] = CH_QUOTE;
            CH_BSLASH: res.bytes[0] = CH_BSLASH;
            CH_SLASH:  res.bytes[0] = CH_SLASH;
            CH_LC_B:   res.bytes[0] = CH_BS;
            CH_LC_F:   res.bytes[0] = CH_FF;
            CH_LC_N:   res.bytes[0] = CH_LF;
            CH_LC_R:   res.bytes[0] = CH_CR;
            CH_LC_T:   res.bytes[0] = CH_TAB;
            CH_LC_U: begin
              phase_nxt   = PH_HEX;
              hex_cnt_nxt = 2'd0;
              part_nxt    = 12'd0;
              res.cnt     = 2'd0;
            end
            default: begin
              fin        = 1'b1;
              fin_status = ST_BADESC;
            end
          endcase
        end
      end
      PH_HEX: begin
        if (eos_i) begin
          fin        = 1'b1;
          fin_status = ST_UNTERM;
        end else if (!hv[4]) begin
          fin        = 1'b1;
          fin_status = ST_BADHEX;
        end else if (hex_cnt_r != 2'd3) begin
          part_nxt    = {part_r[7:0], hv[3:0]};
          hex_cnt_nxt = hex_cnt_r + 2'd1;
          res.cnt     = 2'd0;
        end else begin
          hex_cnt_nxt = 2'd0;
          part_nxt    = 12'd0;
          if (cp[15:11] == 5'b11011) begin
            fin        = 1'b1;
            fin_status = ST_SURR;
          end else begin
            phase_nxt = PH_STR;
            if (cp[15:7] == 9'd0) begin
              res.bytes[0] = cp[7:0];
            end else if (cp[15:11] == 5'd0) begin
              res.cnt      = 2'd2;
              res.bytes[0] = {3'b110, cp[10:6]};
              res.bytes[1] = {2'b10, cp[5:0]};
            end else begin
              res.cnt      = 2'd3;
              res.bytes[0] = {4'b1110, cp[15:12]};
              res.bytes[1] = {2'b10, cp[11:6]};
              res.bytes[2] = {2'b10, cp[5:0]};
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // done and every error: single zero-byte result, back to idle
    if (fin) begin
      res.cnt     = 2'd1;
      res.status  = fin_status;
      res.bytes   = '0;
      phase_nxt   = PH_IDLE;
      hex_cnt_nxt = 2'd0;
      part_nxt    = 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hex_cnt_r <= 2'd0;
      part_r    <= 12'd0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jsu_out_buf.sv -----
// Result register: holds the results of one request and shifts them out one per cycle while out_stall is low.
`default_nettype none

module jsu_out_buf
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire jsu_result_t res,
  output logic             free,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_status,
  output logic             out_last
);

  logic [1:0]              cnt_r, cnt_nxt;
  logic [MAX_RES-1:0][7:0] bytes_r, bytes_nxt;
  jsu_status_t             status_r, status_nxt;
  logic                    fire;

  assign out_valid  = (cnt_r != 2'd0);
  assign out_byte   = bytes_r[0];
  assign out_status = status_r;
  assign out_last   = (cnt_r == 2'd1);
  assign fire       = out_valid && !out_stall;
  assign free       = !out_valid || (fire && out_last);

  always_comb begin
    cnt_nxt    = cnt_r;
    bytes_nxt  = bytes_r;
    status_nxt = status_r;
    if (load) begin
      cnt_nxt    = res.cnt;
      bytes_nxt  = res.bytes;
      status_nxt = res.status;
    end else if (fire) begin
      // advance to the next byte of a multi-byte sequence
      cnt_nxt   = cnt_r - 2'd1;
      bytes_nxt = {8'h00, bytes_r[MAX_RES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r  <= bytes_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/json_string_unescape_utf8.sv -----
// Top level: JSON string unescaper with UTF-8 output of \u escapes.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   in_byte, in_end_of_source
//  out_     output     out_valid/out_stall out_byte, out_status, out_last
//
// One request per cycle when each request yields at most one result and the output does not stall.
// A completed \u escape above 007F yields two or three bytes; the input holds
// (in_stall) while they drain, one per cycle unless out_stall holds them.
// Path: input register, then decode into the result register.
// rst_n is synchronous; it clears the escape state and empties both registers.
// An output stall holds the result register and, once the input register is
// full, backs up to in_stall.
`default_nettype none

module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_end_of_source,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_status,
  output logic             out_last
);

  logic        a_valid_r;
  logic [7:0]  a_byte_r;
  logic        a_eos_r;
  logic        a_take;
  logic        ob_free;
  logic        in_fire;
  jsu_result_t res;

  assign a_take   = a_valid_r && ob_free;
  assign in_stall = a_valid_r && !ob_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_take) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_byte_r <= in_byte;
      a_eos_r  <= in_end_of_source;
    end
  end

  jsu_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (a_take),
    .byte_i (a_byte_r),
    .eos_i  (a_eos_r),
    .res    (res)
  );

  jsu_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (a_take),
    .res        (res),
    .free       (ob_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DATA |-> out_last && out_byte == 8'h00)
    else $error("done or error result not a single zero byte");

  a_seq_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && out_status == ST_DATA)
    else $error("multi-byte sequence broken");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && !(out_last && !out_stall))
    else $error("input held without a pending result");

  a_lead_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_byte[7:6] == 2'b10)
    else $error("continuation byte malformed");

endmodule

`default_nettype wire

// ----- dv/json_string_unescape_utf8_tb.sv -----
// Testbench for the JSON string unescaper: directed and random byte streams checked against a predictor.
`timescale 1ns / 100ps

module json_string_unescape_utf8_tb
  import jsu_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [7:0]  data;
    jsu_status_t status;
    logic        last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_source = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_status;
  logic       out_last;

  decoded_t   decoded_q[$];
  decoded_t   head;
  int         mismatch_cnt = 0;
  int         sent_cnt = 0;
  int         cycle_cnt = 0;
  int         stall_left = 0;
  bit         idle_in = 1'b1;
  bit         idle_out = 1'b1;

  // Predictor state
  jsu_phase_t  scan_phase = PH_IDLE;
  logic [1:0]  digit_cnt = 2'd0;
  logic [11:0] cp_acc = 12'd0;

  json_string_unescape_utf8 i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] escape_letter(input int idx);
    case (idx)
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return CH_LC_B;
      4:       return CH_LC_F;
      5:       return CH_LC_N;
      6:       return CH_LC_R;
      default: return CH_LC_T;
    endcase
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] b);
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B, CH_LC_F,
      CH_LC_N, CH_LC_R, CH_LC_T, CH_LC_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Bias toward the UTF-8 length boundaries and the surrogate range edges.
  function automatic logic [15:0] pick_code_point();
    logic [15:0] r;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 9))
          0:       r = 16'h0000;
          1:       r = 16'h007F;
          2:       r = 16'h0080;
          3:       r = 16'h07FF;
          4:       r = 16'h0800;
          5:       r = 16'hD7FF;
          6:       r = 16'hE000;
          7:       r = 16'hFFFF;
          8:       r = 16'hD800;
          default: r = 16'hDFFF;
        endcase
      end
      1, 2:    r = 16'($urandom_range(0, 16'h007F));
      3, 4:    r = 16'($urandom_range(16'h0080, 16'h07FF));
      5, 6, 7: begin
        r = 16'($urandom_range(16'h0800, 16'hF7FF));
        if (r >= 16'hD800) r = r + 16'h0800;
      end
      8:       r = 16'($urandom_range(0, 16'hFFFF));
      default: r = 16'($urandom_range(16'hD800, 16'hDFFF));
    endcase
    return r;
  endfunction

  function automatic void push_decoded(input logic [7:0] data, input jsu_status_t st,
                                       input logic last);
    decoded_t d;
    d.data   = data;
    d.status = st;
    d.last   = last;
    decoded_q.push_back(d);
  endfunction

  function automatic void end_string(input jsu_status_t st);
    push_decoded(8'h00, st, 1'b1);
    scan_phase = PH_IDLE;
    digit_cnt  = 2'd0;
    cp_acc     = 12'd0;
  endfunction

  // Advance the predictor by one accepted request.
  function automatic void unescape_byte(input logic [7:0] b, input logic eos);
    int          nib;
    logic [15:0] cp;
    logic [7:0]  lit;
    bit          is_lit;
    nib = nibble_of(b);
    is_lit = 1'b1;
    lit = b;
    if (scan_phase == PH_IDLE) begin
      if (!eos && b == CH_QUOTE) scan_phase = PH_STR;
      else end_string(ST_NOQUOTE);
    end else if (eos) begin
      end_string(ST_UNTERM);
    end else if (scan_phase == PH_STR) begin
      if (b == CH_QUOTE) end_string(ST_DONE);
      else if (b == CH_BSLASH) scan_phase = PH_ESC;
      else push_decoded(b, ST_DATA, 1'b1);
    end else if (scan_phase == PH_ESC) begin
      case (b)
        CH_QUOTE, CH_BSLASH, CH_SLASH: lit = b;
        CH_LC_B: lit = CH_BS;
        CH_LC_F: lit = CH_FF;
        CH_LC_N: lit = CH_LF;
        CH_LC_R: lit = CH_CR;
        CH_LC_T: lit = CH_TAB;
        CH_LC_U: begin
          is_lit     = 1'b0;
          scan_phase = PH_HEX;
          digit_cnt  = 2'd0;
          cp_acc     = 12'd0;
        end
        default: begin
          is_lit = 1'b0;
          end_string(ST_BADESC);
        end
      endcase
      if (is_lit) begin
        push_decoded(lit, ST_DATA, 1'b1);
        scan_phase = PH_STR;
      end
    end else begin
      if (nib < 0) begin
        end_string(ST_BADHEX);
      end else if (digit_cnt < 2'd3) begin
        cp_acc    = {cp_acc[7:0], 4'(nib)};
        digit_cnt = digit_cnt + 2'd1;
      end else begin
        cp        = {cp_acc, 4'(nib)};
        digit_cnt = 2'd0;
        cp_acc    = 12'd0;
        if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
          end_string(ST_SURR);
        end else begin
          scan_phase = PH_STR;
          if (cp < 16'h0080) begin
            push_decoded(cp[7:0], ST_DATA, 1'b1);
          end else if (cp < 16'h0800) begin
            push_decoded({3'b110, cp[10:6]}, ST_DATA, 1'b0);
            push_decoded({2'b10, cp[5:0]}, ST_DATA, 1'b1);
          end else begin
            push_decoded({4'b1110, cp[15:12]}, ST_DATA, 1'b0);
            push_decoded({2'b10, cp[11:6]}, ST_DATA, 1'b0);
            push_decoded({2'b10, cp[5:0]}, ST_DATA, 1'b1);
          end
        end
      end
    end
  endfunction

  // Drive one request and hold it until accepted; valid stays high on return.
  task automatic send_req(input logic [7:0] b, input logic eos);
    int gap;
    gap = 0;
    if (idle_in && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid         <= 1'b0;
      in_byte          <= 8'($urandom);
      in_end_of_source <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_source <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    unescape_byte(b, eos);
    sent_cnt++;
  endtask

  task automatic send_u_escape(input logic [15:0] cp);
    int i;
    send_req(CH_BSLASH, 1'b0);
    send_req(CH_LC_U, 1'b0);
    for (i = 3; i >= 0; i--) begin
      send_req(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
    end
  endtask

  // Mostly well-formed string with random content and an occasional broken ending.
  task automatic send_random_string();
    int          n;
    int          i;
    int          k;
    logic [7:0]  b;
    logic [15:0] cp;
    send_req(CH_QUOTE, 1'b0);
    n = $urandom_range(0, 10);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
          send_req(b, 1'b0);
        end
        4, 5: begin
          send_req(CH_BSLASH, 1'b0);
          send_req(escape_letter($urandom_range(0, 7)), 1'b0);
        end
        default: begin
          cp = pick_code_point();
          send_u_escape(cp);
          // A surrogate drops the string back to idle.
          if (scan_phase == PH_IDLE) return;
        end
      endcase
    end
    case ($urandom_range(0, 19))
      0: send_req(8'($urandom), 1'b1);
      1: begin
        send_req(CH_BSLASH, 1'b0);
        do b = 8'($urandom); while (is_escape_letter(b));
        send_req(b, 1'b0);
      end
      2, 3: begin
        send_req(CH_BSLASH, 1'b0);
        send_req(CH_LC_U, 1'b0);
        k = $urandom_range(0, 3);
        repeat (k) send_req(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
        do b = 8'($urandom); while (nibble_of(b) >= 0);
        send_req(b, 1'($urandom_range(0, 1)));
      end
      4: begin
        send_req(CH_BSLASH, 1'b0);
        send_req(8'($urandom), 1'b1);
      end
      default: send_req(CH_QUOTE, 1'b0);
    endcase
  endtask

  task automatic test_idle_rejects();
    send_req(8'h41, 1'b0);
    send_req(8'hFF, 1'b1);
  endtask

  task automatic test_raw_bytes();
    send_req(CH_QUOTE, 1'b0);
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
  endtask

  task automatic test_bad_escape();
    send_req(CH_BSLASH, 1'b0);
    send_req(8'h71, 1'b0);
  endtask

  task automatic test_unicode();
    send_req(CH_QUOTE, 1'b0);
    send_u_escape(16'h0000);
    send_u_escape(16'hD800);
  endtask

  task automatic test_bad_hex();
    send_req(CH_QUOTE, 1'b0);
    send_req(CH_BSLASH, 1'b0);
    send_req(CH_LC_U, 1'b0);
    send_req(8'h78, 1'b0);
  endtask

  task automatic test_unterminated();
    send_req(CH_QUOTE, 1'b0);
    send_req(8'h00, 1'b1);
  endtask

  task automatic test_close();
    send_req(CH_QUOTE, 1'b0);
    send_req(CH_QUOTE, 1'b0);
  endtask

  task automatic test_random_strings(input int target);
    while (sent_cnt < target) send_random_string();
  endtask

  task automatic test_noise();
    logic [7:0] b;
    repeat (16) begin
      b = ($urandom_range(0, 4) == 0) ? CH_QUOTE : 8'($urandom);
      send_req(b, ($urandom_range(0, 7) == 0));
    end
    // End of source always lands back in idle.
    send_req(8'($urandom), 1'b1);
  endtask

  task automatic test_tail_no_idle(input int target);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    while (sent_cnt < target) send_random_string();
  endtask

  // Result side stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_out && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %h status %0d last %b",
                 $time, out_byte, out_status, out_last);
        mismatch_cnt++;
      end else begin
        head = decoded_q.pop_front();
        if (out_byte !== head.data) begin
          $display("%0t: out_byte mismatch, expected %h, actual %h",
                   $time, head.data, out_byte);
          mismatch_cnt++;
        end
        if (out_status !== head.status) begin
          $display("%0t: out_status mismatch, expected %0d, actual %0d",
                   $time, head.status, out_status);
          mismatch_cnt++;
        end
        if (out_last !== head.last) begin
          $display("%0t: out_last mismatch, expected %b, actual %b",
                   $time, head.last, out_last);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, decoded_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_rejects();
    test_raw_bytes();
    test_bad_escape();
    test_unicode();
    test_bad_hex();
    test_unterminated();
    test_close();
    test_random_strings(110);
    test_noise();
    test_random_strings(165);
    test_tail_no_idle(225);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/jsu_out_buf.sv
sv/json_string_unescape_utf8.sv
dv/json_string_unescape_utf8_tb.sv
